/* hw/rtl/spmf_pkg.sv */
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared types and constants for the strict-priority multi-level FIFO.
// ----------------------------------------------------------------------------
package spmf_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int LEVELS_DEF = 3;
	localparam int LEVEL_W    = 2;
	localparam int DATA_W     = 32;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Outcome of one request, decided from the queue state.
	typedef struct packed {
		status_t              status;
		logic [LEVEL_W-1:0]   served;
		logic                 wr_en;
		logic                 rd_en;
	} op_plan_t;

endpackage

/* hw/rtl/spmf_ctrl.sv */
// ----------------------------------------------------------------------------
// spmf_ctrl
// Per-level head/tail pointers and fill counts; picks the level and entry
// that a request touches and updates the pointers when it is accepted.
// ----------------------------------------------------------------------------
module spmf_ctrl
	import spmf_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int LEVELS = LEVELS_DEF,
	localparam int PTR_W  = $clog2(DEPTH),
	localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               command,
	input  logic [LEVEL_W-1:0] level,
	output op_plan_t           plan,
	output logic [LIDX_W-1:0]  lvl_sel,
	output logic [PTR_W-1:0]   ptr_sel
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [PTR_W-1:0]  head_q [LEVELS];
	logic [PTR_W-1:0]  tail_q [LEVELS];
	logic [CNT_W-1:0]  cnt_q  [LEVELS];

	logic              lvl_ok;
	logic              enq_ok;
	logic [LIDX_W-1:0] enq_idx;
	logic [LIDX_W-1:0] deq_idx;
	logic              found;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign lvl_ok  = int'(level) < LEVELS;
	assign enq_idx = LIDX_W'(level);
	assign enq_ok  = lvl_ok && (cnt_q[enq_idx] != CNT_W'(DEPTH));

	// lowest-numbered non-empty level wins
	always_comb begin
		found   = 1'b0;
		deq_idx = '0;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (cnt_q[k] != '0) begin
				found   = 1'b1;
				deq_idx = LIDX_W'(k);
			end
		end
	end

	always_comb begin
		plan.status = ST_DONE;
		plan.served = '0;
		plan.wr_en  = 1'b0;
		plan.rd_en  = 1'b0;
		lvl_sel     = '0;
		ptr_sel     = '0;
		if (command == CMD_ENQ) begin
			if (enq_ok) begin
				plan.served = level;
				plan.wr_en  = 1'b1;
				lvl_sel     = enq_idx;
				ptr_sel     = tail_q[enq_idx];
			end else begin
				plan.status = ST_FULL;
			end
		end else begin
			if (found) begin
				plan.served = LEVEL_W'(deq_idx);
				plan.rd_en  = 1'b1;
				lvl_sel     = deq_idx;
				ptr_sel     = head_q[deq_idx];
			end else begin
				plan.status = ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LEVELS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				cnt_q[k]  <= '0;
			end
		end else if (fire) begin
			if (plan.wr_en) begin
				tail_q[lvl_sel] <= advance(ptr_sel);
				cnt_q[lvl_sel]  <= cnt_q[lvl_sel] + 1'b1;
			end
			if (plan.rd_en) begin
				head_q[lvl_sel] <= advance(ptr_sel);
				cnt_q[lvl_sel]  <= cnt_q[lvl_sel] - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/strict_priority_multi_fifo_top.sv */
// An accepted request's response is registered and is presented in the cycle after it.
// Throughput: one request per cycle unless stalled; the entry store's single synchronous
// port is touched once per request, so a dequeue may follow an enqueue at once.
// A response held by rsp_stall stalls the request side.
// Reset clears all pointers and fill counts; the entry store is not cleared.
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo_top
// Several circular FIFOs of signed words sharing one memory, served by
// strict priority with level 0 highest.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_top
	import spmf_pkg::*;
#(
	parameter int DEPTH  = DEPTH_DEF,
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     command,
	input  logic [LEVEL_W-1:0]       level,
	input  logic signed [DATA_W-1:0] in_data,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] out_data,
	output logic [LEVEL_W-1:0]       served_level
);

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int LIDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ENTRIES = LEVELS * DEPTH;
	localparam int ADDR_W  = $clog2(ENTRIES);

	logic [DATA_W-1:0]  mem [ENTRIES];

	op_plan_t           plan;
	logic [LIDX_W-1:0]  lvl_sel;
	logic [PTR_W-1:0]   ptr_sel;
	logic [ADDR_W-1:0]  addr;
	logic               fire;

	logic               rsp_valid_q;
	status_t            status_s1;
	logic [LEVEL_W-1:0] served_s1;
	logic               deq_ok_s1;
	logic [DATA_W-1:0]  rd_data_s1;

	spmf_ctrl #(
		.DEPTH  (DEPTH),
		.LEVELS (LEVELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.command (command),
		.level   (level),
		.plan    (plan),
		.lvl_sel (lvl_sel),
		.ptr_sel (ptr_sel)
	);

	// hold requests while a response waits on a stalled consumer
	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;
	assign addr      = ADDR_W'(int'(lvl_sel) * DEPTH + int'(ptr_sel));

	always_ff @(posedge clk) begin
		if (fire && plan.wr_en) begin
			mem[addr] <= in_data;
		end
		if (fire && plan.rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1 <= plan.status;
			served_s1 <= plan.served;
			deq_ok_s1 <= plan.rd_en;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_s1;
	assign served_level = served_s1;
	assign out_data     = deq_ok_s1 ? rd_data_s1 : '0;

endmodule
